### design/ufc_pkg.sv
// ----------------------------------------------------------------------------
// ufc_pkg: shared types and constants of the udp/ipv4 frame classifier
// header offsets, protocol codes, status codes and the ones'-complement adder
// ----------------------------------------------------------------------------
`default_nettype none

package ufc_pkg;

	// widest frame length the classifier can ever report (limit of 65535 plus one)
	localparam int unsigned LEN_W = 17;

	localparam logic [6:0]  ETH_HDR_BYTES  = 7'd14;
	localparam logic [6:0]  UDP_HDR_BYTES  = 7'd8;
	localparam logic [16:0] MIN_FRAME_LEN  = 17'd42;
	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [3:0]  IP_VERSION_4   = 4'd4;
	localparam logic [5:0]  IP_MIN_HDR     = 6'd20;
	localparam logic [7:0]  PROTO_UDP      = 8'd17;
	localparam logic [15:0] CKSUM_ONES     = 16'hffff;

	typedef enum logic [2:0] {
		ST_OK            = 3'd0,
		ST_TOO_SHORT     = 3'd1,
		ST_NOT_IPV4      = 3'd2,
		ST_FRAGMENTED    = 3'd3,
		ST_NOT_UDP       = 3'd4,
		ST_BAD_IP_CKSUM  = 3'd5,
		ST_BAD_UDP_CKSUM = 3'd6,
		ST_TOO_LONG      = 3'd7
	} status_t;

	// header fields and running sums of one complete frame
	typedef struct packed {
		logic             too_long;
		logic [LEN_W-1:0] frame_len;
		logic [15:0]      ether_type;
		logic [7:0]       version_hlen;
		logic [15:0]      fragment;
		logic [7:0]       protocol;
		logic [15:0]      ip_cksum;
		logic [15:0]      udp_len;
		logic [15:0]      udp_cksum;
		logic [15:0]      ip_sum;
		logic [15:0]      udp_sum;
	} snapshot_t;

	typedef struct packed {
		status_t     status;
		logic [6:0]  payload_offset;
		logic [13:0] payload_length;
	} result_t;

	// 16-bit ones'-complement add with end-around carry
	function automatic logic [15:0] oc_add(input logic [15:0] acc, input logic [15:0] w);
		logic [16:0] s;
		logic [16:0] f;
		s = {1'b0, acc} + {1'b0, w};
		f = {1'b0, s[15:0]} + {16'b0, s[16]};
		return f[15:0];
	endfunction

endpackage

`default_nettype wire

### design/ufc_parser.sv
// ----------------------------------------------------------------------------
// ufc_parser: per-byte header capture and checksum accumulation
// holds the frame state and presents the frame snapshot including the current byte
// ----------------------------------------------------------------------------
`default_nettype none

module ufc_parser #(
	parameter int unsigned MAX_FRAME_BYTES = 16384
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               take,
	input  wire logic [7:0]         frame_byte,
	input  wire logic               frame_last,
	output ufc_pkg::snapshot_t      snap
);

	localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES + 2);
	localparam logic [POS_W-1:0] POS_MAX   = POS_W'(MAX_FRAME_BYTES);
	localparam logic [POS_W-1:0] POS_SAT   = POS_W'(MAX_FRAME_BYTES + 1);
	localparam logic [POS_W-1:0] POS_IP    = POS_W'(14);
	localparam logic [POS_W-1:0] POS_ETH_H = POS_W'(12);
	localparam logic [POS_W-1:0] POS_ETH_L = POS_W'(13);

	logic [POS_W-1:0] pos_q;
	logic [15:0] ether_type_q, total_len_q, fragment_q, ip_cksum_q;
	logic [15:0] udp_len_q, udp_cksum_q, ip_sum_q, udp_sum_q;
	logic [7:0]  version_hlen_q, protocol_q;

	logic [POS_W-1:0] pos_n;
	logic [15:0] ether_type_n, total_len_n, fragment_n, ip_cksum_n;
	logic [15:0] udp_len_n, udp_cksum_n, ip_sum_n, udp_sum_n;
	logic [7:0]  version_hlen_n, protocol_n;

	logic             in_range, hi, in_ip, in_udp;
	logic [15:0]      part;
	logic [5:0]       ihl;
	logic [6:0]       udp_start;
	logic [POS_W-1:0] ip_off_full, udp_off;
	logic [5:0]       ip_off;

	function automatic logic [15:0] set_byte(input logic [15:0] w, input logic [7:0] b,
		input logic high);
		return high ? {b, w[7:0]} : {w[15:8], b};
	endfunction

	always_comb begin
		in_range    = pos_q < POS_MAX;
		hi          = ~pos_q[0];
		part        = hi ? {frame_byte, 8'h00} : {8'h00, frame_byte};
		pos_n       = (pos_q == POS_SAT) ? pos_q : pos_q + POS_W'(1);

		ether_type_n   = ether_type_q;
		version_hlen_n = version_hlen_q;
		total_len_n    = total_len_q;
		fragment_n     = fragment_q;
		protocol_n     = protocol_q;
		ip_cksum_n     = ip_cksum_q;
		udp_len_n      = udp_len_q;
		udp_cksum_n    = udp_cksum_q;
		ip_sum_n       = ip_sum_q;
		udp_sum_n      = udp_sum_q;

		if (in_range && (pos_q == POS_ETH_H || pos_q == POS_ETH_L)) begin
			ether_type_n = set_byte(ether_type_q, frame_byte, hi);
		end
		if (in_range && pos_q == POS_IP) begin
			version_hlen_n = frame_byte;
		end

		// header length uses the version byte even when it arrives now
		ihl         = {version_hlen_n[3:0], 2'b00};
		udp_start   = ufc_pkg::ETH_HDR_BYTES + 7'(ihl);
		in_ip       = in_range && pos_q >= POS_IP && pos_q < POS_W'(udp_start);
		in_udp      = in_range && pos_q >= POS_W'(udp_start);
		ip_off_full = pos_q - POS_IP;
		ip_off      = ip_off_full[5:0];
		udp_off     = pos_q - POS_W'(udp_start);

		if (in_ip) begin
			if (ip_off == 6'd2 || ip_off == 6'd3) total_len_n = set_byte(total_len_q, frame_byte, hi);
			if (ip_off == 6'd6 || ip_off == 6'd7) fragment_n = set_byte(fragment_q, frame_byte, hi);
			if (ip_off == 6'd9) protocol_n = frame_byte;
			if (ip_off == 6'd10 || ip_off == 6'd11) begin
				ip_cksum_n = set_byte(ip_cksum_q, frame_byte, hi);
			end else begin
				ip_sum_n = ufc_pkg::oc_add(ip_sum_q, part);
			end
			// source and destination address feed the pseudo-header
			if (ip_off >= 6'd12 && ip_off < 6'd20) udp_sum_n = ufc_pkg::oc_add(udp_sum_q, part);
		end

		if (in_udp) begin
			if (udp_off == POS_W'(4) || udp_off == POS_W'(5)) begin
				udp_len_n = set_byte(udp_len_q, frame_byte, hi);
			end
			if (udp_off == POS_W'(6) || udp_off == POS_W'(7)) begin
				udp_cksum_n = set_byte(udp_cksum_q, frame_byte, hi);
			end else if (udp_off < POS_W'(8) ||
				ufc_pkg::LEN_W'(udp_off) < ufc_pkg::LEN_W'(udp_len_q)) begin
				udp_sum_n = ufc_pkg::oc_add(udp_sum_q, part);
			end
		end
	end

	always_comb begin
		snap.too_long     = pos_n > POS_MAX;
		snap.frame_len    = ufc_pkg::LEN_W'(pos_n);
		snap.ether_type   = ether_type_n;
		snap.version_hlen = version_hlen_n;
		snap.fragment     = fragment_n;
		snap.protocol     = protocol_n;
		snap.ip_cksum     = ip_cksum_n;
		snap.udp_len      = udp_len_n;
		snap.udp_cksum    = udp_cksum_n;
		snap.ip_sum       = ip_sum_n;
		snap.udp_sum      = udp_sum_n;
	end

	// total length is kept for completeness but never judged
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q          <= '0;
			ether_type_q   <= '0;
			version_hlen_q <= '0;
			total_len_q    <= '0;
			fragment_q     <= '0;
			protocol_q     <= '0;
			ip_cksum_q     <= '0;
			udp_len_q      <= '0;
			udp_cksum_q    <= '0;
			ip_sum_q       <= '0;
			udp_sum_q      <= '0;
		end else if (take) begin
			if (frame_last) begin
				pos_q          <= '0;
				ether_type_q   <= '0;
				version_hlen_q <= '0;
				total_len_q    <= '0;
				fragment_q     <= '0;
				protocol_q     <= '0;
				ip_cksum_q     <= '0;
				udp_len_q      <= '0;
				udp_cksum_q    <= '0;
				ip_sum_q       <= '0;
				udp_sum_q      <= '0;
			end else begin
				pos_q          <= pos_n;
				ether_type_q   <= ether_type_n;
				version_hlen_q <= version_hlen_n;
				total_len_q    <= total_len_n;
				fragment_q     <= fragment_n;
				protocol_q     <= protocol_n;
				ip_cksum_q     <= ip_cksum_n;
				udp_len_q      <= udp_len_n;
				udp_cksum_q    <= udp_cksum_n;
				ip_sum_q       <= ip_sum_n;
				udp_sum_q      <= udp_sum_n;
			end
		end
	end

endmodule

`default_nettype wire

### design/ufc_verdict.sv
// ----------------------------------------------------------------------------
// ufc_verdict: ordered header checks and checksum compare for one frame
// turns a frame snapshot into status, payload offset and payload length
// ----------------------------------------------------------------------------
`default_nettype none

module ufc_verdict (
	input  wire ufc_pkg::snapshot_t snap,
	input  wire logic               verify,
	output ufc_pkg::result_t        res
);

	logic [5:0]                ihl;
	logic [6:0]                hdr_end;
	logic [ufc_pkg::LEN_W-1:0] udp_end;
	logic [15:0]               udp_acc, udp_calc, udp_raw;
	logic                      ip_bad, udp_bad;
	ufc_pkg::status_t          st;

	always_comb begin
		ihl      = {snap.version_hlen[3:0], 2'b00};
		hdr_end  = ufc_pkg::ETH_HDR_BYTES + 7'(ihl) + ufc_pkg::UDP_HDR_BYTES;
		udp_end  = ufc_pkg::LEN_W'(ufc_pkg::ETH_HDR_BYTES) + ufc_pkg::LEN_W'(ihl)
			+ ufc_pkg::LEN_W'(snap.udp_len);
		ip_bad   = snap.ip_cksum != ~snap.ip_sum;
		udp_acc  = ufc_pkg::oc_add(ufc_pkg::oc_add(snap.udp_sum, 16'(ufc_pkg::PROTO_UDP)),
			snap.udp_len);
		udp_raw  = ~udp_acc;
		udp_calc = (udp_raw == 16'h0000) ? ufc_pkg::CKSUM_ONES : udp_raw;
		// zero means no checksum sent; all-ones and zero are the same value
		udp_bad  = snap.udp_cksum != 16'h0000 && snap.udp_cksum != udp_calc &&
			!(snap.udp_cksum == ufc_pkg::CKSUM_ONES && udp_calc == 16'h0000);

		priority if (snap.too_long) st = ufc_pkg::ST_TOO_LONG;
		else if (snap.frame_len < ufc_pkg::MIN_FRAME_LEN) st = ufc_pkg::ST_TOO_SHORT;
		else if (snap.ether_type != ufc_pkg::ETHERTYPE_IPV4) st = ufc_pkg::ST_NOT_IPV4;
		else if (snap.version_hlen[7:4] != ufc_pkg::IP_VERSION_4 || ihl < ufc_pkg::IP_MIN_HDR)
			st = ufc_pkg::ST_NOT_IPV4;
		else if (snap.frame_len < ufc_pkg::LEN_W'(hdr_end)) st = ufc_pkg::ST_TOO_SHORT;
		else if (snap.fragment[13:0] != 14'd0) st = ufc_pkg::ST_FRAGMENTED;
		else if (snap.protocol != ufc_pkg::PROTO_UDP) st = ufc_pkg::ST_NOT_UDP;
		else if (snap.udp_len < 16'(ufc_pkg::UDP_HDR_BYTES)) st = ufc_pkg::ST_TOO_SHORT;
		else if (snap.frame_len < udp_end) st = ufc_pkg::ST_TOO_SHORT;
		else if (verify && ip_bad) st = ufc_pkg::ST_BAD_IP_CKSUM;
		else if (verify && udp_bad) st = ufc_pkg::ST_BAD_UDP_CKSUM;
		else st = ufc_pkg::ST_OK;

		res.status = st;
		if (st == ufc_pkg::ST_OK) begin
			res.payload_offset = hdr_end;
			res.payload_length = 14'(snap.udp_len - 16'(ufc_pkg::UDP_HDR_BYTES));
		end else begin
			res.payload_offset = '0;
			res.payload_length = '0;
		end
	end

endmodule

`default_nettype wire

### design/udp_ipv4_frame_classifier.sv
// ----------------------------------------------------------------------------
// udp_ipv4_frame_classifier: ethernet/ipv4/udp header classifier
// byte-streaming frame parser giving one verdict per frame on its last byte
// ----------------------------------------------------------------------------
// The block takes one frame byte per cycle, back to back, starting at the
// destination MAC, and delivers one result item for the item flagged
// frame_last. Each byte passes an input register, the parser (header
// field capture plus two 16-bit ones'-complement running sums), a snapshot
// register for finished frames, and a result register holding status,
// payload offset and payload length. The sustained rate is one byte per
// cycle; only a frame's last byte can be held, while the snapshot stage
// waits on a stalled result side.
// Checks in order: over-long frame (more than MAX_FRAME_BYTES), runt,
// ethertype/version/header length, truncated headers, fragments, protocol,
// UDP length bounds, then the IPv4 and UDP checksums when verify_checksums
// is set. The register lies at byte address 0 of the APB-style port; change
// it only while no frame is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module udp_ipv4_frame_classifier #(
	parameter int unsigned MAX_FRAME_BYTES = 16384
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// frame byte channel
	input  wire logic        frame_valid,
	output logic             frame_stall,
	input  wire logic [7:0]  frame_byte,
	input  wire logic        frame_last,
	// verdict channel
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [2:0]       status,
	output logic [6:0]       payload_offset,
	output logic [13:0]      payload_length
);

	localparam logic REG_VERIFY = 1'b0;  // register index, taken from paddr[2]

	// configuration
	logic verify_q;
	logic cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = (paddr[2] == REG_VERIFY) ? {31'b0, verify_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verify_q <= 1'b0;
		end else if (cfg_write && paddr[2] == REG_VERIFY) begin
			verify_q <= pwdata[0];
		end
	end

	// pipeline control: input stage, snapshot stage, result register
	logic               valid_s1, last_s1;
	logic [7:0]         byte_s1;
	logic               valid_s2;
	ufc_pkg::snapshot_t snap_s2;
	ufc_pkg::result_t   res_q;
	logic               res_valid_q;

	logic res_free, s2_free, s2_move, s1_move, s1_free, frame_take;

	assign res_free    = !res_valid_q || !result_stall;
	assign s2_move     = valid_s2 && res_free;
	assign s2_free     = !valid_s2 || res_free;
	// bytes that end no frame only update the parser and never wait on the result side
	assign s1_move     = valid_s1 && (!last_s1 || s2_free);
	assign s1_free     = !valid_s1 || s1_move;
	assign frame_stall = !s1_free;
	assign frame_take  = frame_valid && !frame_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= frame_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_take) begin
			byte_s1 <= frame_byte;
			last_s1 <= frame_last;
		end
	end

	// parser: frame state plus snapshot including the byte in the input stage
	ufc_pkg::snapshot_t snap_now;

	ufc_parser #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (s1_move),
		.frame_byte (byte_s1),
		.frame_last (last_s1),
		.snap       (snap_now)
	);

	// snapshot of a finished frame waits here for the verdict logic
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= s1_move && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && last_s1) begin
			snap_s2 <= snap_now;
		end
	end

	// verdict and result register
	ufc_pkg::result_t res_now;

	ufc_verdict u_verdict (
		.snap   (snap_s2),
		.verify (verify_q),
		.res    (res_now)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_free) begin
			res_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_move) begin
			res_q <= res_now;
		end
	end

	assign result_valid   = res_valid_q;
	assign status         = res_q.status;
	assign payload_offset = res_q.payload_offset;
	assign payload_length = res_q.payload_length;

	// a frame's last byte leaving the input stage always lands in the snapshot stage
	assert property (@(posedge clk) disable iff (!arst_n)
		s1_move && last_s1 |=> valid_s2)
		else $error("last byte of frame lost before verdict");

	// a waiting snapshot is not dropped while the result side is full
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !res_free |=> valid_s2 && $stable(snap_s2))
		else $error("frame snapshot dropped or changed while waiting");

	// payload fields are zero unless the frame passed every check
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status != ufc_pkg::ST_OK |-> payload_offset == 7'd0 &&
		payload_length == 14'd0)
		else $error("payload fields set on a rejected frame");

	// an accepted frame has its payload past a full ipv4 and udp header
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == ufc_pkg::ST_OK |-> payload_offset >= 7'd42 &&
		payload_offset <= 7'd82)
		else $error("payload offset out of range on accepted frame");

endmodule

`default_nettype wire
